// ----- rtl/sinpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sinpi_pkg
// shared constants and binary32 arithmetic helpers for the sin(pi*x) pipeline
// ----------------------------------------------------------------------------
package sinpi_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [31:0] HALF_BITS = 32'h3F00_0000;

    // polynomial coefficients as binary32 encodings
    localparam logic [31:0] COEF0 = 32'h40490FDB;
    localparam logic [31:0] COEF1 = 32'hC0A55DE1;
    localparam logic [31:0] COEF2 = 32'h40233457;
    localparam logic [31:0] COEF3 = 32'hBF192655;
    localparam logic [31:0] COEF4 = 32'h3D9ED718;

    localparam int NUM_STAGES = 12;

    typedef struct packed {
        logic        vld;
        logic        nan;
        logic        odd;
        logic        sgn;
        logic [31:0] f;
        logic [31:0] s;
        logic [31:0] r;
    } t_stage;

    // count of leading zeros of a 48-bit word, used for normalising
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // round a magnitude to binary32: m has its leading one at bit 47 when
    // the biased exponent e is its value; subnormal and overflow handled
    function automatic logic [31:0] pack_rne(input logic sgn, input logic signed [10:0] e,
                                             input logic [47:0] m);
        logic [47:0]       mm;
        logic signed [10:0] ee;
        logic [5:0]        lz;
        logic [24:0]       q;
        logic              g;
        logic              st;
        logic [25:0]       rq;
        logic [11:0]       sh;
        logic [31:0]       res;
        if (m == 48'd0) begin
            res = {sgn, 31'd0};
        end else begin
            lz = lzc48(m);
            mm = m << lz;
            ee = e - 11'(lz);
            if (ee < 11'sd1) begin
                sh = 12'(11'sd1 - ee);
                if (sh > 12'd47) begin
                    mm = {47'd0, |mm};
                end else begin
                    mm = (mm >> sh[5:0]) | {47'd0, |(mm & ((48'd1 << sh[5:0]) - 48'd1))};
                end
                ee = 11'sd0;
            end
            q  = {1'b0, mm[47:24]};
            g  = mm[23];
            st = |mm[22:0];
            rq = {1'b0, q} + 26'(g && (st || q[0]));
            if (rq[24]) begin
                // mantissa carried into a new bit
                ee = ee + 11'sd1;
                rq = rq >> 1;
            end else if (ee == 11'sd0 && rq[23]) begin
                ee = 11'sd1;
            end
            if (ee >= 11'sd255) begin
                res = {sgn, 8'hFF, 23'd0};
            end else begin
                res = {sgn, ee[7:0], rq[22:0]};
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic [23:0]       ma;
        logic [23:0]       mb;
        logic [47:0]       p;
        logic signed [10:0] e;
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        p  = ma * mb;
        e  = 11'(a[30:23] == 8'd0 ? 8'd1 : a[30:23])
           + 11'(b[30:23] == 8'd0 ? 8'd1 : b[30:23]) - 11'sd126;
        return pack_rne(a[31] ^ b[31], e, p);
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]       x;
        logic [31:0]       y;
        logic [47:0]       mx;
        logic [47:0]       my;
        logic [47:0]       sum;
        logic [7:0]        ex;
        logic [7:0]        ey;
        logic [8:0]        d;
        logic              stk;
        logic [31:0]       res;
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {1'b0, (x[30:23] != 8'd0), x[22:0], 23'd0};
        my = {1'b0, (y[30:23] != 8'd0), y[22:0], 23'd0};
        d  = {1'b0, ex} - {1'b0, ey};
        if (d > 9'd47) begin
            stk = |my;
            my  = {47'd0, stk};
        end else begin
            stk = |(my & ((48'd1 << d[5:0]) - 48'd1));
            my  = (my >> d[5:0]) | {47'd0, stk};
        end
        sum = (x[31] == y[31]) ? mx + my : mx - my;
        if (sum == 48'd0) begin
            res = {x[31] & y[31], 31'd0};
        end else begin
            res = pack_rne(x[31], 11'(ex) + 11'sd1, sum);
        end
        return res;
    endfunction

    function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
        return a[30:0] > b[30:0];
    endfunction

endpackage

// ----- rtl/sinpi_float32_unit_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sinpi_float32_unit_top
// sin(pi*x) on binary32 values, fully pipelined
// ----------------------------------------------------------------------------
// channel | direction | signals
// input   | in        | i_valid, o_stall, i_x_bits
// output  | out       | o_valid, i_stall, o_sine_bits
//
// one item per cycle, except while the output is stalled with a valid item
// twelve register stages: two for reduction, ten for the polynomial
// synchronous active-low reset clears only the valid bits
// the whole pipe holds while the output is stalled with a valid item;
// o_stall follows i_stall only in that case, and bubbles are held in place
// ----------------------------------------------------------------------------
module sinpi_float32_unit_top import sinpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sine_bits
);

    t_stage w_mid;
    logic   w_en;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    sinpi_reduce u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (i_valid),
        .i_x_bits (i_x_bits),
        .o_stage  (w_mid)
    );

    sinpi_poly u_poly (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_stage     (w_mid),
        .o_sine_bits (o_sine_bits),
        .o_vld       (o_valid)
    );

endmodule

// ----- rtl/sinpi_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sinpi_reduce
// argument reduction: fractional part, fold above one half, parity, nan
// ----------------------------------------------------------------------------
module sinpi_reduce import sinpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_x_bits,
    output t_stage      o_stage
);

    t_stage      r_a;
    t_stage      n_a;
    t_stage      r_b;
    t_stage      n_b;

    always_comb begin
        logic [31:0] mag;
        logic [7:0]  e;
        logic [4:0]  sh;
        logic [23:0] mant;
        logic [31:0] ipart;
        mag   = {1'b0, i_x_bits[30:0]};
        e     = mag[30:23];
        mant  = {1'b1, mag[22:0]};
        ipart = 32'd0;
        n_a     = '0;
        n_a.vld = i_vld;
        n_a.sgn = i_x_bits[31];
        n_a.nan = (e == 8'hFF);
        n_a.f   = mag;
        sh      = 5'(8'd150 - e);
        if (mag >= 32'h4B00_0000) begin
            n_a.f   = 32'd0;
            n_a.odd = (e == 8'd150) & mag[0];
        end else if (mag >= ONE_BITS) begin
            n_a.odd = mant[sh];
            ipart   = mag & ~((32'd1 << sh) - 32'd1);
        end
        // subtraction of the integer part is exact, done as a float add
        if (ipart != 32'd0) begin
            n_a.f = fadd(mag, {1'b1, ipart[30:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
            r_b.vld <= 1'b0;
        end else if (i_en) begin
            r_a.vld <= n_a.vld;
            r_b.vld <= n_b.vld;
        end
        if (i_en) begin
            {r_a.nan, r_a.odd, r_a.sgn}    <= {n_a.nan, n_a.odd, n_a.sgn};
            {r_a.f, r_a.s, r_a.r}          <= {n_a.f, n_a.s, n_a.r};
            {r_b.nan, r_b.odd, r_b.sgn}    <= {n_b.nan, n_b.odd, n_b.sgn};
            {r_b.f, r_b.s, r_b.r}          <= {n_b.f, n_b.s, n_b.r};
        end
    end

    always_comb begin
        n_b = r_a;
        if (fgt(r_a.f, HALF_BITS)) begin
            n_b.f = fadd(ONE_BITS, {1'b1, r_a.f[30:0]});
        end
    end

    assign o_stage = r_b;

endmodule

// ----- rtl/sinpi_poly.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sinpi_poly
// horner polynomial in f*f, one multiply or add per register stage
// ----------------------------------------------------------------------------
module sinpi_poly import sinpi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_stage      i_stage,
    output logic [31:0] o_sine_bits,
    output logic        o_vld
);

    localparam int NOPS = 10;

    t_stage r_p [NOPS];
    t_stage n_p [NOPS];

    function automatic logic [31:0] coef(input int k);
        case (k)
            0:       return COEF0;
            1:       return COEF1;
            2:       return COEF2;
            3:       return COEF3;
            default: return COEF4;
        endcase
    endfunction

    // op 0: s=f*f; then mul/add pairs for k=3..0; op 9: f*r
    always_comb begin
        n_p[0]   = i_stage;
        n_p[0].s = fmul(i_stage.f, i_stage.f);
        n_p[0].r = COEF4;
        for (int i = 1; i < NOPS; i++) begin
            n_p[i] = r_p[i-1];
            if (i == NOPS - 1) begin
                n_p[i].r = fmul(r_p[i-1].f, r_p[i-1].r);
            end else if (i % 2 == 1) begin
                n_p[i].r = fmul(r_p[i-1].s, r_p[i-1].r);
            end else begin
                n_p[i].r = fadd(coef(4 - i / 2), r_p[i-1].r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NOPS; i++) begin
            if (!i_rst_n) begin
                r_p[i].vld <= 1'b0;
            end else if (i_en) begin
                r_p[i].vld <= n_p[i].vld;
            end
            if (i_en) begin
                {r_p[i].nan, r_p[i].odd, r_p[i].sgn} <= {n_p[i].nan, n_p[i].odd, n_p[i].sgn};
                {r_p[i].f, r_p[i].s, r_p[i].r}       <= {n_p[i].f, n_p[i].s, n_p[i].r};
            end
        end
    end

    assign o_vld       = r_p[NOPS-1].vld;
    assign o_sine_bits = r_p[NOPS-1].nan ? QNAN_BITS
                       : {r_p[NOPS-1].sgn ^ r_p[NOPS-1].odd, r_p[NOPS-1].r[30:0]};

endmodule
